// ===== rtl/pulse_pedestal_amplitude_fit_top_macros.svh =====
`ifndef PULSE_PEDESTAL_AMPLITUDE_FIT_TOP_MACROS_SVH
`define PULSE_PEDESTAL_AMPLITUDE_FIT_TOP_MACROS_SVH

// condition implies consequence in the same cycle, outside reset
`define PPAF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppaf: implication check failed");

// condition implies consequence in the next cycle, outside reset
`define PPAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppaf: next-cycle check failed");

// next-cycle check that also runs during reset
`define PPAF_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ppaf: reset check failed");

`endif

// ===== rtl/ppaf_pkg.sv =====
`timescale 1ns / 1ps

package ppaf_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int MAX_POINTS   = 256;
    localparam int PEDESTAL_GAP = 10;
    localparam int NPTS_W       = 9;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int SLOT_W       = $clog2(PEDESTAL_GAP);
    localparam int SUM_W        = 20;
    localparam int RECENT_W     = 16;
    localparam int FRAC_W       = 8;
    localparam int BG_W         = 20;
    localparam int AMP_W        = 28;
    localparam int DIVD_W       = SUM_W + FRAC_W;
    localparam int CNT_W        = $clog2(DIVD_W);
    localparam int PROD_W       = BG_W + NPTS_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_N_POINTS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

    typedef struct packed {
        logic                no_signal;
        logic [IDX_W-1:0]    cross_idx;
        logic [SUM_W-1:0]    ped_sum;
        logic [SUM_W-1:0]    run_sum;
        logic [SAMPLE_W-1:0] run_min;
        logic [NPTS_W-1:0]   n_pts;
    } t_job;

endpackage

// ===== rtl/ppaf_front.sv =====
`timescale 1ns / 1ps

module ppaf_front import ppaf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NPTS_W-1:0]   i_n_pts,
    input  logic [SAMPLE_W-1:0] i_threshold,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output t_job                o_job
);

    logic [IDX_W-1:0]    r_idx;
    logic [SLOT_W-1:0]   r_slot;
    logic [SUM_W-1:0]    r_run_sum;
    logic [SAMPLE_W-1:0] r_run_min;
    logic                r_found;
    logic [IDX_W-1:0]    r_cross;
    logic [SUM_W-1:0]    r_ped_sum;
    logic [RECENT_W-1:0] r_recent;
    logic [SAMPLE_W-1:0] r_ring [PEDESTAL_GAP];

    logic                accept;
    logic                last;
    logic                cross_now;
    logic                n_found;
    logic [IDX_W-1:0]    n_cross;
    logic [SUM_W-1:0]    n_ped_sum;
    logic [SUM_W-1:0]    n_run_sum;
    logic [SAMPLE_W-1:0] n_run_min;
    logic [RECENT_W-1:0] n_recent;
    logic [SLOT_W-1:0]   n_slot;

    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        last      = ({1'b0, r_idx} + NPTS_W'(1)) >= i_n_pts;
        cross_now = !r_found && (i_sample < i_threshold);
        n_found   = r_found | cross_now;
        n_cross   = cross_now ? r_idx : r_cross;
        if (cross_now) begin
            if (r_idx > IDX_W'(PEDESTAL_GAP)) begin
                n_ped_sum = r_run_sum - SUM_W'(r_recent);
            end else begin
                n_ped_sum = '0;
            end
        end else begin
            n_ped_sum = r_ped_sum;
        end
        n_run_sum = r_run_sum + SUM_W'(i_sample);
        n_run_min = (i_sample < r_run_min) ? i_sample : r_run_min;
        if (r_idx >= IDX_W'(PEDESTAL_GAP)) begin
            n_recent = r_recent - RECENT_W'(r_ring[r_slot]) + RECENT_W'(i_sample);
        end else begin
            n_recent = r_recent + RECENT_W'(i_sample);
        end
        n_slot = (r_slot == SLOT_W'(PEDESTAL_GAP - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    assign o_job_valid       = accept & last;
    assign o_job.no_signal   = !n_found || (n_cross <= IDX_W'(PEDESTAL_GAP));
    assign o_job.cross_idx   = n_cross;
    assign o_job.ped_sum     = n_ped_sum;
    assign o_job.run_sum     = n_run_sum;
    assign o_job.run_min     = n_run_min;
    assign o_job.n_pts       = i_n_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_slot    <= '0;
            r_run_sum <= '0;
            r_run_min <= '1;
            r_found   <= 1'b0;
            r_cross   <= '0;
            r_ped_sum <= '0;
            r_recent  <= '0;
        end else if (accept) begin
            if (last) begin
                r_idx     <= '0;
                r_slot    <= '0;
                r_run_sum <= '0;
                r_run_min <= '1;
                r_found   <= 1'b0;
                r_cross   <= '0;
                r_ped_sum <= '0;
                r_recent  <= '0;
            end else begin
                r_idx     <= r_idx + IDX_W'(1);
                r_slot    <= n_slot;
                r_run_sum <= n_run_sum;
                r_run_min <= n_run_min;
                r_found   <= n_found;
                r_cross   <= n_cross;
                r_ped_sum <= n_ped_sum;
                r_recent  <= n_recent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_sample;
        end
    end

endmodule

// ===== rtl/ppaf_queue.sv =====
`timescale 1ns / 1ps

module ppaf_queue import ppaf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// ===== rtl/ppaf_back.sv =====
`timescale 1ns / 1ps

module ppaf_back import ppaf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  t_job                i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_status,
    output logic [IDX_W-1:0]    o_start_time,
    output logic [BG_W-1:0]     o_background,
    output logic [AMP_W-1:0]    o_amplitude,
    output logic [SAMPLE_W-1:0] o_minimum
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_FIN  = 4'b1000
    } t_back_state;

    t_back_state         r_state;
    t_job                r_job;
    logic [IDX_W-1:0]    r_rem;
    logic [DIVD_W-1:0]   r_dq;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    logic                r_status;
    logic [IDX_W-1:0]    r_start;
    logic [BG_W-1:0]     r_bg;
    logic [AMP_W-1:0]    r_amp;
    logic [SAMPLE_W-1:0] r_min;

    logic [IDX_W-1:0]  len;
    logic [IDX_W:0]    trial;
    logic [IDX_W:0]    diff;
    logic              ge;
    logic [IDX_W-1:0]  n_rem;
    logic [BG_W-1:0]   bg;
    logic [PROD_W-1:0] neg;
    logic [PROD_W-1:0] amp_full;
    logic              out_free;

    always_comb begin
        len      = r_job.cross_idx - IDX_W'(PEDESTAL_GAP);
        trial    = {r_rem, r_dq[DIVD_W-1]};
        diff     = trial - {1'b0, len};
        ge       = trial >= {1'b0, len};
        n_rem    = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
        bg       = r_dq[BG_W-1:0];
        neg      = PROD_W'({r_job.run_sum, FRAC_W'(0)});
        amp_full = (r_prod > neg) ? r_prod - neg : '0;
        out_free = !r_out_valid || i_out_ready;
    end

    assign o_job_ready  = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_start_time = r_start;
    assign o_background = r_bg;
    assign o_amplitude  = r_amp;
    assign o_minimum    = r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.no_signal ? S_FIN : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                    r_dq  <= {i_job.ped_sum, FRAC_W'(0)};
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_dq  <= {r_dq[DIVD_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_MUL: begin
                r_prod <= PROD_W'(bg) * PROD_W'(r_job.n_pts);
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_job.no_signal) begin
                        r_status <= 1'b1;
                        r_start  <= '0;
                        r_bg     <= '0;
                        r_amp    <= '0;
                        r_min    <= '0;
                    end else begin
                        r_status <= 1'b0;
                        r_start  <= r_job.cross_idx;
                        r_bg     <= bg;
                        r_amp    <= amp_full[AMP_W-1:0];
                        r_min    <= r_job.run_min;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/pulse_pedestal_amplitude_fit_top.sv =====
// Pedestal-subtracted pulse integral over one waveform of ADC samples.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets
// the samples per waveform (0 acts as 1, above 256 acts as 256), index 1 the
// threshold; other indexes are ignored. Reset gives 256 samples, threshold 2048.
// Sample channel (i_in_valid/o_in_ready): one 12-bit sample per request, one per
// cycle while the internal job queue has room.
// Result channel (o_out_valid/i_out_ready): one request per waveform, after its
// last sample. A fit passes through the bit-serial divider (one quotient bit per
// cycle) and a multiply; a no-signal result skips both. Back to back, the fit
// unit takes a new job only once it is through with the last one, so very
// short waveforms are bounded by the divider rather than the sample rate.
// A two-entry job queue sits between the sample front end and the fit unit, and
// the result is held in an output register: a stalled receiver first stops the
// fit unit, then fills the queue, then drops o_in_ready.
// Reset (synchronous, active low) clears the waveform state, the queue and the
// output valid, and restores the register defaults.
`timescale 1ns / 1ps

module pulse_pedestal_amplitude_fit_top import ppaf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_status,
    output logic [IDX_W-1:0]      o_start_time,
    output logic [BG_W-1:0]       o_background,
    output logic [AMP_W-1:0]      o_amplitude,
    output logic [SAMPLE_W-1:0]   o_minimum
);

    logic [NPTS_W-1:0]   r_n_points;
    logic [SAMPLE_W-1:0] r_threshold;
    logic [NPTS_W-1:0]   n_pts_eff;

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_n_points == '0) begin
            n_pts_eff = NPTS_W'(1);
        end else if (r_n_points > NPTS_W'(MAX_POINTS)) begin
            n_pts_eff = NPTS_W'(MAX_POINTS);
        end else begin
            n_pts_eff = r_n_points;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_points  <= NPTS_W'(256);
            r_threshold <= SAMPLE_W'(2048);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_N_POINTS: begin
                    r_n_points <= i_cfg_data[NPTS_W-1:0];
                end
                CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ppaf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_pts     (n_pts_eff),
        .i_threshold (r_threshold),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    ppaf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    ppaf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (pop_valid),
        .o_job_ready  (pop_ready),
        .i_job        (pop_job),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_start_time (o_start_time),
        .o_background (o_background),
        .o_amplitude  (o_amplitude),
        .o_minimum    (o_minimum)
    );

endmodule

// ===== rtl/ppaf_checker.sv =====
`timescale 1ns / 1ps
`include "pulse_pedestal_amplitude_fit_top_macros.svh"

module ppaf_checker import ppaf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_status,
    input logic [IDX_W-1:0]    o_start_time,
    input logic [BG_W-1:0]     o_background,
    input logic [AMP_W-1:0]    o_amplitude,
    input logic [SAMPLE_W-1:0] o_minimum
);

    `PPAF_ASSERT_RESET(a_reset_clears_valid, i_clk, !i_rst_n, !o_out_valid)

    `PPAF_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_amplitude) && $stable(o_background))

    `PPAF_ASSERT_IMPLY(a_no_signal_zero, i_clk, i_rst_n, o_out_valid && o_status, o_start_time == '0 && o_background == '0 && o_amplitude == '0 && o_minimum == '0)

    `PPAF_ASSERT_IMPLY(a_fit_has_pedestal, i_clk, i_rst_n, o_out_valid && !o_status, o_start_time > IDX_W'(PEDESTAL_GAP))

endmodule

bind pulse_pedestal_amplitude_fit_top ppaf_checker u_checker (.*);

// ===== bench/ppaf_fit_checker.sv =====
`timescale 1ns / 1ps

module ppaf_fit_checker import ppaf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_status,
    input  logic [IDX_W-1:0]      i_start_time,
    input  logic [BG_W-1:0]       i_background,
    input  logic [AMP_W-1:0]      i_amplitude,
    input  logic [SAMPLE_W-1:0]   i_minimum,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count,
    output int                    o_fit_count
);

    localparam logic FIT_DONE  = 1'b0;
    localparam logic NO_SIGNAL = 1'b1;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(2048);

    typedef struct packed {
        logic                status;
        logic [IDX_W-1:0]    start_time;
        logic [BG_W-1:0]     background;
        logic [AMP_W-1:0]    amplitude;
        logic [SAMPLE_W-1:0] minimum;
    } t_fit;

    t_fit fit_q[$];
    t_fit seen_fit;
    t_fit want_fit;

    logic [NPTS_W-1:0]   cfg_points;
    logic [SAMPLE_W-1:0] cfg_threshold;
    logic [NPTS_W-1:0]   wave_index;
    logic [SUM_W-1:0]    wave_sum;
    logic [SAMPLE_W-1:0] wave_min;
    logic                crossed;
    logic [IDX_W-1:0]    cross_index;
    logic [SUM_W-1:0]    pedestal_sum;
    logic [SAMPLE_W-1:0] ring [PEDESTAL_GAP];
    logic [RECENT_W-1:0] ring_sum;

    task automatic report_fault(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_wave();
        wave_index   = '0;
        wave_sum     = '0;
        wave_min     = '1;
        crossed      = 1'b0;
        cross_index  = '0;
        pedestal_sum = '0;
        ring_sum     = '0;
    endtask

    task automatic fold_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned     points;
        int unsigned     slot;
        longint unsigned span;
        longint unsigned bg;
        longint unsigned pos;
        longint unsigned neg;
        t_fit            fit;
        points = (cfg_points == 0) ? 1 : cfg_points;
        if (points > MAX_POINTS) begin
            points = MAX_POINTS;
        end
        slot = wave_index % PEDESTAL_GAP;
        if (!crossed && s < cfg_threshold) begin
            crossed      = 1'b1;
            cross_index  = wave_index[IDX_W-1:0];
            pedestal_sum = (wave_index > PEDESTAL_GAP) ? SUM_W'(wave_sum - ring_sum) : '0;
        end
        wave_sum = wave_sum + s;
        if (s < wave_min) begin
            wave_min = s;
        end
        if (wave_index >= PEDESTAL_GAP) begin
            ring_sum = ring_sum - ring[slot];
        end
        ring[slot] = s;
        ring_sum   = ring_sum + s;
        if (wave_index + 1 < points) begin
            wave_index = wave_index + 1'b1;
        end else begin
            fit = '0;
            if (!crossed || cross_index <= PEDESTAL_GAP) begin
                fit.status = NO_SIGNAL;
            end else begin
                span = cross_index - PEDESTAL_GAP;
                bg   = (64'(pedestal_sum) << FRAC_W) / span;
                pos  = bg * points;
                neg  = 64'(wave_sum) << FRAC_W;
                fit.status     = FIT_DONE;
                fit.start_time = cross_index;
                fit.background = bg[BG_W-1:0];
                fit.amplitude  = (pos > neg) ? AMP_W'(pos - neg) : '0;
                fit.minimum    = wave_min;
            end
            fit_q.push_back(fit);
            clear_wave();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_points    = NPTS_W'(MAX_POINTS);
            cfg_threshold = THRESHOLD_RESET;
            for (int k = 0; k < PEDESTAL_GAP; k++) begin
                ring[k] = '0;
            end
            clear_wave();
            fit_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_N_POINTS: begin
                        cfg_points = i_cfg_data[NPTS_W-1:0];
                    end
                    CFG_THRESHOLD: begin
                        cfg_threshold = i_cfg_data[SAMPLE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen_fit = {i_status, i_start_time, i_background, i_amplitude, i_minimum};
                if (fit_q.size() == 0) begin
                    report_fault($sformatf("result with nothing pending: %p", seen_fit));
                end else begin
                    want_fit = fit_q.pop_front();
                    o_result_count++;
                    if (want_fit.status == FIT_DONE) begin
                        o_fit_count++;
                    end
                    if (seen_fit.status !== want_fit.status) begin
                        report_fault($sformatf("status got %0d want %0d",
                            seen_fit.status, want_fit.status));
                    end
                    if (seen_fit.start_time !== want_fit.start_time) begin
                        report_fault($sformatf("start_time got %0d want %0d",
                            seen_fit.start_time, want_fit.start_time));
                    end
                    if (seen_fit.background !== want_fit.background) begin
                        report_fault($sformatf("background got %0d want %0d",
                            seen_fit.background, want_fit.background));
                    end
                    if (seen_fit.amplitude !== want_fit.amplitude) begin
                        report_fault($sformatf("amplitude got %0d want %0d",
                            seen_fit.amplitude, want_fit.amplitude));
                    end
                    if (seen_fit.minimum !== want_fit.minimum) begin
                        report_fault($sformatf("minimum got %0d want %0d",
                            seen_fit.minimum, want_fit.minimum));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fold_sample(i_sample);
            end
        end
        o_pending = fit_q.size();
    end

endmodule

// ===== bench/pulse_pedestal_amplitude_fit_top_test.sv =====
`timescale 1ns / 1ps

module pulse_pedestal_amplitude_fit_top_test;
    import ppaf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);
    localparam logic [SAMPLE_W-1:0]  FULL_SCALE = '1;
    localparam int THRESHOLD_RESET = 2048;
    localparam int SETTLE_CYCLES   = 64;
    localparam int STALL_LIMIT     = 2000;
    localparam int SAMPLE_TARGET   = 1050;
    localparam int RESULT_TARGET   = 40;
    localparam int IDLE_PCT        = 21;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_status;
    logic [IDX_W-1:0]      o_start_time;
    logic [BG_W-1:0]       o_background;
    logic [AMP_W-1:0]      o_amplitude;
    logic [SAMPLE_W-1:0]   o_minimum;

    int          fail_count;
    int          pending_fits;
    int          results_seen;
    int          fits_seen;
    int          samples_sent;
    int          reg_writes;
    int          quiet_cycles;
    int unsigned thr_now    = THRESHOLD_RESET;
    int unsigned points_now = MAX_POINTS;
    bit          steady;

    pulse_pedestal_amplitude_fit_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_start_time (o_start_time),
        .o_background (o_background),
        .o_amplitude  (o_amplitude),
        .o_minimum    (o_minimum)
    );

    ppaf_fit_checker fit_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_start_time   (o_start_time),
        .i_background   (o_background),
        .i_amplitude    (o_amplitude),
        .i_minimum      (o_minimum),
        .o_fail_count   (fail_count),
        .o_pending      (pending_fits),
        .o_result_count (results_seen),
        .o_fit_count    (fits_seen)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("pulse_pedestal_amplitude_fit_top regression: fail");
            $finish;
        end
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (index == CFG_N_POINTS) begin
            points_now = (data[NPTS_W-1:0] == 0) ? 1 : data[NPTS_W-1:0];
            if (points_now > MAX_POINTS) begin
                points_now = MAX_POINTS;
            end
        end else if (index == CFG_THRESHOLD) begin
            thr_now = data[SAMPLE_W-1:0];
        end
        reg_writes++;
        @(posedge i_clk);
    endtask

    // drop valid, drain pending results, then let the front end go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_fits != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pulse_spot(input int unsigned len);
        if (len > PEDESTAL_GAP + 1 && $urandom_range(9) > 1) begin
            return $urandom_range(len - 1, PEDESTAL_GAP + 1);
        end else if ($urandom_range(3) == 0) begin
            return -1;
        end
        return $urandom_range(len - 1, 0);
    endfunction

    task automatic send_wave(input int unsigned len, input int pulse_at);
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] s;
        int unsigned         headroom;
        int                  dip_len;
        bit                  noisy;
        bit                  overshoot;
        level     = SAMPLE_W'($urandom_range(FULL_SCALE, thr_now));
        headroom  = FULL_SCALE - level;
        dip_len   = $urandom_range(6, 1);
        noisy     = ($urandom_range(99) < 12);
        overshoot = ($urandom_range(99) < 10);
        if (headroom > 24) begin
            headroom = 24;
        end
        for (int j = 0; j < len; j++) begin
            if (noisy) begin
                s = SAMPLE_W'($urandom_range(FULL_SCALE));
            end else if (pulse_at >= 0 && j >= pulse_at && j < pulse_at + dip_len
                         && thr_now != 0) begin
                s = SAMPLE_W'($urandom_range(thr_now - 1));
            end else if (overshoot && pulse_at >= 0 && j >= pulse_at) begin
                s = FULL_SCALE;
            end else begin
                s = level + SAMPLE_W'($urandom_range(headroom));
            end
            push_sample(s);
        end
    endtask

    task automatic run_phase(input int k);
        logic [CFG_DATA_W-1:0] n_data;
        int unsigned           pick;
        int unsigned           part;
        int                    waves;
        pick = $urandom_range(99);
        if (k == 3) begin
            n_data = '1;
        end else if (pick < 4) begin
            n_data = '0;
        end else if (pick < 14) begin
            n_data = CFG_DATA_W'($urandom_range(PEDESTAL_GAP, 1));
        end else begin
            n_data = CFG_DATA_W'($urandom_range(36, PEDESTAL_GAP + 1));
        end
        n_data[CFG_DATA_W-1:NPTS_W] = 3'($urandom_range(7));
        write_reg(CFG_N_POINTS, n_data);
        if (k == 1) begin
            write_reg(CFG_THRESHOLD, '0);
        end else if (k == 2) begin
            write_reg(CFG_THRESHOLD, '1);
        end else if ($urandom_range(9) == 0) begin
            write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(FULL_SCALE)));
        end else if ($urandom_range(3) != 0) begin
            write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(3800, 300)));
        end
        waves = (k == 3) ? 1 : $urandom_range(4, 1);
        for (int w = 0; w < waves; w++) begin
            send_wave(points_now, pulse_spot(points_now));
        end
        if (k != 3 && points_now > 1 && $urandom_range(99) < 25) begin
            part = $urandom_range(points_now - 1, 1);
            send_wave(part, pulse_spot(points_now));
            settle();
            if ($urandom_range(1) == 0) begin
                write_reg(CFG_N_POINTS, CFG_DATA_W'($urandom_range(part, 1)));
            end else begin
                write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(3800, 300)));
            end
            send_wave(points_now, pulse_spot(points_now));
        end
        settle();
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: full-length waveform crossing on its last sample
        send_wave(MAX_POINTS, MAX_POINTS - 1);
        settle();

        write_reg(CFG_N_POINTS, CFG_DATA_W'(1));
        push_sample(FULL_SCALE);
        push_sample('0);
        settle();
        write_reg(CFG_N_POINTS, '0);
        write_reg(CFG_UNUSED, '1);
        push_sample('0);
        settle();

        // crossing right at the gap leaves no pedestal
        write_reg(CFG_N_POINTS, CFG_DATA_W'(PEDESTAL_GAP + 2));
        write_reg(CFG_THRESHOLD, '1);
        repeat (PEDESTAL_GAP) push_sample(FULL_SCALE);
        push_sample('0);
        push_sample(FULL_SCALE);
        settle();
        // one sample past the gap: full-scale background, single-sample pedestal
        repeat (PEDESTAL_GAP + 1) push_sample(FULL_SCALE);
        push_sample('0);
        settle();

        phase = 0;
        while (samples_sent < SAMPLE_TARGET || results_seen < RESULT_TARGET) begin
            steady = (phase >= 8 && phase < 12);
            run_phase(phase);
            phase++;
        end
        steady = 1'b0;
        settle();

        $display("covered %0d samples over %0d phases, %0d register writes",
                 samples_sent, phase, reg_writes);
        $display("checked %0d waveform results, %0d of them fits", results_seen, fits_seen);
        if (fail_count == 0) begin
            $display("pulse_pedestal_amplitude_fit_top regression: pass");
        end else begin
            $display("pulse_pedestal_amplitude_fit_top regression: fail");
        end
        $finish;
    end

endmodule
